// ===== rtl/gbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the go-back-n sender window unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam logic [1:0] FIRST_SEQ = 2'd2;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1,
    REG_FULL_PACKETS  = 2'd2,
    REG_HAS_TAIL      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    EV_SENT     = 3'd0,
    EV_REFUSED  = 3'd1,
    EV_RESENT   = 3'd2,
    EV_ADVANCED = 3'd3,
    EV_DUP_ACK  = 3'd4,
    EV_FINISHED = 3'd5,
    EV_IGNORED  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    PT_HEADER = 2'd0,
    PT_FULL   = 2'd1,
    PT_TAIL   = 2'd2
  } ptype_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ack_num;
    logic        checksum_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] seq;
    logic [1:0]  packet_type;
    logic [5:0]  in_flight;
    logic [7:0]  dup_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [15:0] wdata;
  } cfg_t;

endpackage

// ===== rtl/gbn_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gbn_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gbn_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_alu
// Shared add and compare unit: sum = a + b, lt = a < c, eq = (a + b) == c.
// ----------------------------------------------------------------------------
module gbn_alu #(
  parameter int W = 17
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] c_i,
  output logic [W-1:0] sum_o,
  output logic         lt_o,
  output logic         eq_o
);

  assign sum_o = a_i + b_i;
  assign lt_o  = (a_i < c_i);
  assign eq_o  = (sum_o == c_i);

endmodule

// ===== rtl/gbn_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_cfg
// Configuration registers and the derived window and sequence limits.
// ----------------------------------------------------------------------------
module gbn_cfg #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  gbn_chan_if.sink                              cfg_i,
  output logic [5:0]                            eff_window_o,
  output logic [15:0]                           timeout_o,
  output logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] limit_o,
  output logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] tail_seq_o,
  output logic                                  has_tail_o
);

  localparam int CW  = ((SEQ_BITS > 16) ? SEQ_BITS : 16) + 1;
  localparam int CAP = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
  localparam logic [CW-1:0] SEQ_MAX = {{(CW-SEQ_BITS){1'b0}}, {SEQ_BITS{1'b1}}};

  logic [5:0]    window_q;
  logic [15:0]   timeout_q;
  logic [15:0]   full_q;
  logic          tail_q;
  logic [CW-1:0] lim_raw;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= 6'd4;
      timeout_q <= 16'd1000;
      full_q    <= 16'd0;
      tail_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (gbn_pkg::cfg_reg_e'(cfg_i.data.reg_index))
        gbn_pkg::REG_WINDOW_SIZE:   window_q  <= cfg_i.data.wdata[5:0];
        gbn_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg_i.data.wdata;
        gbn_pkg::REG_FULL_PACKETS:  full_q    <= cfg_i.data.wdata;
        gbn_pkg::REG_HAS_TAIL:      tail_q    <= cfg_i.data.wdata[0];
        default: ;
      endcase
    end
  end

  // effective window and final sendable limit
  assign eff_window_o = (window_q > 6'(CAP)) ? 6'(CAP) : window_q;
  assign lim_raw      = CW'(full_q) + CW'(3) + CW'(tail_q);
  assign limit_o      = (lim_raw > SEQ_MAX) ? SEQ_MAX : lim_raw;
  assign tail_seq_o   = CW'(full_q) + CW'(3);
  assign has_tail_o   = tail_q;
  assign timeout_o    = timeout_q;

endmodule

// ===== rtl/gbn_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_seq
// Sequencer: window state, per-step operand selection for the shared unit,
// resend scan and the result register.
// ----------------------------------------------------------------------------
module gbn_seq #(
  parameter int SEQ_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  gbn_chan_if.sink                                   req_i,
  gbn_chan_if.source                                 res_o,
  input  logic [5:0]                                 eff_window_i,
  input  logic [15:0]                                timeout_i,
  input  logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] limit_i,
  input  logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] tail_seq_i,
  input  logic                                       has_tail_i,
  output logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] alu_a_o,
  output logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] alu_b_o,
  output logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] alu_c_o,
  input  logic [((SEQ_BITS > 16) ? SEQ_BITS : 16):0] alu_sum_i,
  input  logic                                       alu_lt_i,
  input  logic                                       alu_eq_i
);

  localparam int SW = SEQ_BITS;
  localparam int CW = ((SEQ_BITS > 16) ? SEQ_BITS : 16) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND_WIN,
    S_SEND_CHK,
    S_SEND_LIM,
    S_SEND_TMR,
    S_ACK_CHK,
    S_ACK_BASE,
    S_ACK_TMR,
    S_ACK_FIN,
    S_ACK_DUP,
    S_TICK,
    S_RESEND,
    S_EMIT
  } state_e;

  state_e          state_q;
  logic [15:0]     ack_q;
  logic            ok_q;
  logic [SW-1:0]   base_q;
  logic [SW-1:0]   next_q;
  logic [15:0]     elapsed_q;
  logic [15:0]     prev_q;
  logic            prev_valid_q;
  logic [7:0]      rep_q;
  logic            done_q;
  logic [CW-1:0]   tmp_q;
  logic            flag_q;
  logic            adv_q;
  logic [SW-1:0]   scan_q;
  gbn_pkg::event_e pend_ev_q;
  logic [15:0]     pend_seq_q;
  gbn_pkg::ptype_e pend_pt_q;
  logic            pend_last_q;
  logic            out_valid_q;
  gbn_pkg::res_t   out_q;
  logic [SW-1:0]   flight;
  logic            out_free;

  function automatic gbn_pkg::ptype_e ptype_of(input logic [CW-1:0] s,
                                               input logic [CW-1:0] tail_seq,
                                               input logic has_tail);
    if (s == CW'(gbn_pkg::FIRST_SEQ)) begin
      return gbn_pkg::PT_HEADER;
    end else if (has_tail && (s == tail_seq)) begin
      return gbn_pkg::PT_TAIL;
    end
    return gbn_pkg::PT_FULL;
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;
  assign flight      = next_q - base_q;
  assign out_free    = !out_valid_q || res_o.ready;

  // operand selection for the shared unit
  always_comb begin
    alu_a_o = '0;
    alu_b_o = '0;
    alu_c_o = '0;
    case (state_q)
      S_SEND_WIN: begin
        alu_a_o = CW'(base_q);
        alu_b_o = CW'(eff_window_i);
      end
      S_SEND_CHK: begin
        alu_a_o = CW'(next_q);
        alu_b_o = CW'(1);
        alu_c_o = tmp_q;
      end
      S_SEND_LIM: begin
        alu_a_o = CW'(next_q);
        alu_c_o = limit_i;
      end
      S_SEND_TMR: begin
        alu_a_o = CW'(next_q);
        alu_c_o = CW'(base_q);
      end
      S_ACK_CHK: begin
        alu_a_o = CW'(ack_q);
        alu_b_o = CW'(1);
        alu_c_o = CW'(next_q);
      end
      S_ACK_BASE: begin
        alu_a_o = CW'(ack_q);
        alu_c_o = CW'(base_q);
      end
      S_ACK_TMR: begin
        alu_a_o = CW'(base_q);
        alu_c_o = CW'(next_q);
      end
      S_ACK_FIN: begin
        alu_a_o = CW'(ack_q);
        alu_b_o = CW'(1);
        alu_c_o = limit_i;
      end
      S_ACK_DUP: begin
        alu_a_o = CW'(ack_q);
        alu_c_o = CW'(prev_q);
      end
      S_TICK: begin
        alu_a_o = CW'(elapsed_q);
        alu_b_o = CW'(1);
        alu_c_o = CW'(timeout_i);
      end
      S_RESEND: begin
        alu_a_o = CW'(scan_q);
        alu_b_o = CW'(1);
        alu_c_o = CW'(next_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= SW'(gbn_pkg::FIRST_SEQ);
      next_q       <= SW'(gbn_pkg::FIRST_SEQ);
      elapsed_q    <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      rep_q        <= '0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && res_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            ack_q <= req_i.data.ack_num;
            ok_q  <= req_i.data.checksum_ok;
            case (gbn_pkg::kind_e'(req_i.data.kind))
              gbn_pkg::KIND_SEND: state_q <= S_SEND_WIN;
              gbn_pkg::KIND_ACK:  state_q <= S_ACK_CHK;
              gbn_pkg::KIND_TICK: state_q <= done_q ? S_IDLE : S_TICK;
              default:            state_q <= S_IDLE;
            endcase
          end
        end
        S_SEND_WIN: begin
          tmp_q   <= alu_sum_i;
          state_q <= S_SEND_CHK;
        end
        S_SEND_CHK: begin
          flag_q  <= alu_lt_i;
          tmp_q   <= alu_sum_i;
          state_q <= S_SEND_LIM;
        end
        S_SEND_LIM: begin
          flag_q  <= flag_q && alu_lt_i && !done_q;
          state_q <= S_SEND_TMR;
        end
        S_SEND_TMR: begin
          pend_seq_q  <= 16'(CW'(next_q));
          pend_last_q <= 1'b1;
          if (flag_q) begin
            if (alu_eq_i) begin
              elapsed_q <= '0;
            end
            next_q    <= tmp_q[SW-1:0];
            pend_ev_q <= gbn_pkg::EV_SENT;
            pend_pt_q <= ptype_of(CW'(next_q), tail_seq_i, has_tail_i);
          end else begin
            pend_ev_q <= gbn_pkg::EV_REFUSED;
            pend_pt_q <= gbn_pkg::PT_HEADER;
          end
          state_q <= S_EMIT;
        end
        S_ACK_CHK: begin
          tmp_q       <= alu_sum_i;
          pend_seq_q  <= ack_q;
          pend_pt_q   <= gbn_pkg::PT_HEADER;
          pend_last_q <= 1'b1;
          if (!ok_q || done_q || !alu_lt_i) begin
            pend_ev_q <= gbn_pkg::EV_IGNORED;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_ACK_BASE;
          end
        end
        S_ACK_BASE: begin
          adv_q <= !alu_lt_i;
          if (!alu_lt_i) begin
            base_q <= tmp_q[SW-1:0];
          end
          state_q <= S_ACK_TMR;
        end
        S_ACK_TMR: begin
          if (!alu_eq_i) begin
            elapsed_q <= '0;
          end
          state_q <= S_ACK_FIN;
        end
        S_ACK_FIN: begin
          if (alu_eq_i) begin
            done_q    <= 1'b1;
            pend_ev_q <= gbn_pkg::EV_FINISHED;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_ACK_DUP;
          end
        end
        S_ACK_DUP: begin
          if (prev_valid_q && alu_eq_i) begin
            if (rep_q != 8'hFF) begin
              rep_q <= rep_q + 8'd1;
            end
            pend_ev_q <= adv_q ? gbn_pkg::EV_ADVANCED : gbn_pkg::EV_DUP_ACK;
          end else begin
            rep_q        <= '0;
            prev_q       <= ack_q;
            prev_valid_q <= 1'b1;
            pend_ev_q    <= adv_q ? gbn_pkg::EV_ADVANCED : gbn_pkg::EV_IGNORED;
          end
          state_q <= S_EMIT;
        end
        S_TICK: begin
          if (alu_lt_i) begin
            elapsed_q <= alu_sum_i[15:0];
            state_q   <= S_IDLE;
          end else begin
            elapsed_q <= '0;
            scan_q    <= base_q;
            state_q   <= S_RESEND;
          end
        end
        S_RESEND: begin
          if (alu_lt_i) begin
            pend_ev_q   <= gbn_pkg::EV_RESENT;
            pend_seq_q  <= 16'(CW'(scan_q));
            pend_pt_q   <= ptype_of(CW'(scan_q), tail_seq_i, has_tail_i);
            pend_last_q <= alu_eq_i;
            scan_q      <= alu_sum_i[SW-1:0];
            state_q     <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.event_res   <= pend_ev_q;
            out_q.seq         <= pend_seq_q;
            out_q.packet_type <= pend_pt_q;
            out_q.in_flight   <= flight[5:0];
            out_q.dup_count   <= rep_q;
            out_q.last        <= pend_last_q;
            if ((pend_ev_q == gbn_pkg::EV_RESENT) && !pend_last_q) begin
              state_q <= S_RESEND;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_base_le_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= next_q) else $error("window base beyond next sequence");

  a_flight_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight <= SW'(32)) else $error("more than 32 packets outstanding");

  a_done_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q) else $error("transfer done flag cleared");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESEND) |-> (scan_q >= base_q && scan_q <= next_q))
    else $error("resend scan outside the window");

endmodule

// ===== rtl/go_back_n_sender_window_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-back-n sender window controller: grants sends, slides the window on
// cumulative acks and resends the outstanding run on timeout.
// ----------------------------------------------------------------------------
//  channel  dir   payload                                          transaction
//  req_i    in    kind, ack_num, checksum_ok                       valid & ready
//  res_o    out   event_res, seq, packet_type, in_flight,          valid & ready
//                 dup_count, last
//  cfg_i    in    reg_index, wdata                                 valid & ready
//
//  sends and acks step in turn through the one shared add and compare unit;
//  a tick is dropped once done or for an unknown kind, and a timeout emits
//  one resend result per outstanding packet, none with nothing outstanding.
//  req_i is ready only while the sequencer is idle; a held result in the
//  output register stalls the sequencer at its next result.
//  rst_ni clears the window to sequence 2 and loads the register defaults.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbn_chan_if.sink    req_i,
  gbn_chan_if.source  res_o,
  gbn_chan_if.sink    cfg_i
);

  localparam int CW = ((SEQ_BITS > 16) ? SEQ_BITS : 16) + 1;

  logic [5:0]    eff_window;
  logic [15:0]   timeout;
  logic [CW-1:0] limit;
  logic [CW-1:0] tail_seq;
  logic          has_tail;
  logic [CW-1:0] alu_a;
  logic [CW-1:0] alu_b;
  logic [CW-1:0] alu_c;
  logic [CW-1:0] alu_sum;
  logic          alu_lt;
  logic          alu_eq;

  gbn_cfg #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .eff_window_o (eff_window),
    .timeout_o    (timeout),
    .limit_o      (limit),
    .tail_seq_o   (tail_seq),
    .has_tail_o   (has_tail)
  );

  gbn_alu #(
    .W (CW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .sum_o (alu_sum),
    .lt_o  (alu_lt),
    .eq_o  (alu_eq)
  );

  gbn_seq #(
    .SEQ_BITS (SEQ_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .res_o        (res_o),
    .eff_window_i (eff_window),
    .timeout_i    (timeout),
    .limit_i      (limit),
    .tail_seq_i   (tail_seq),
    .has_tail_i   (has_tail),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_c_o      (alu_c),
    .alu_sum_i    (alu_sum),
    .alu_lt_i     (alu_lt),
    .alu_eq_i     (alu_eq)
  );

endmodule
